// ===== hdl/srts_pkg.sv =====
// Shared types, constants and helpers for the signed radix-to-symbols converter.
package srts_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_SYMBOLS = 16;

	localparam int SYM_W    = 8;
	localparam int DIGIT_W  = 4;
	localparam int LEN_W    = 5;
	localparam int TBL_W    = 128;
	localparam int CFG_W    = 64;
	localparam int ADDR_W   = 5;
	localparam int STACK_DEPTH = VALUE_WIDTH;
	localparam int PTR_W    = $clog2(STACK_DEPTH);
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int BIT_W    = $clog2(VALUE_WIDTH);

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

	localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
	localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [LEN_W-1:0] RST_BASE_LENGTH  = 5'd10;
	localparam logic [CFG_W-1:0] RST_SYMBOLS_LOW  = 64'h3736353433323130;
	localparam logic [CFG_W-1:0] RST_SYMBOLS_HIGH = 64'h0000000000003938;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DIGIT,
		ST_SIGN,
		ST_RD,
		ST_LD,
		ST_DOUT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic load_in;
		logic div_step;
		logic digit_wr;
		logic rd_en;
		logic cnt_dec;
		logic ld_err;
		logic ld_sign;
		logic ld_digit;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic bit_last;
		logic quot_zero;
		logic cnt_at_max;
		logic cnt_last;
	} stat_t;

	function automatic logic [SYM_W-1:0] table_byte(input logic [TBL_W-1:0] tbl,
			input logic [DIGIT_W-1:0] idx);
		return tbl[SYM_W*idx +: SYM_W];
	endfunction

endpackage

// ===== hdl/srts_ram.sv =====
// Generic single-port-write, registered-read RAM.
module srts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/srts_cfg.sv =====
// Configuration registers, APB access and base validity check.
module srts_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [srts_pkg::ADDR_W-1:0]       paddr,
	input  logic [srts_pkg::CFG_W-1:0]        pwdata,
	output logic [srts_pkg::CFG_W-1:0]        prdata,
	output logic                              pready,
	output logic [srts_pkg::LEN_W-1:0]        radix,
	output logic [srts_pkg::TBL_W-1:0]        sym_tbl,
	output logic                              base_ok
);
	import srts_pkg::*;

	logic [LEN_W-1:0] base_length_q;
	logic [CFG_W-1:0] symbols_low_q;
	logic [CFG_W-1:0] symbols_high_q;
	logic             base_ok_q;
	logic             ok_c;
	logic [1:0]       reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q  <= RST_BASE_LENGTH;
			symbols_low_q  <= RST_SYMBOLS_LOW;
			symbols_high_q <= RST_SYMBOLS_HIGH;
			base_ok_q      <= 1'b1;
		end else begin
			base_ok_q <= ok_c;
			if (wr_en) begin
				case (reg_idx)
					REG_BASE_LENGTH:  base_length_q  <= pwdata[LEN_W-1:0];
					REG_SYMBOLS_LOW:  symbols_low_q  <= pwdata;
					REG_SYMBOLS_HIGH: symbols_high_q <= pwdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE_LENGTH:  prdata = CFG_W'(base_length_q);
			REG_SYMBOLS_LOW:  prdata = symbols_low_q;
			REG_SYMBOLS_HIGH: prdata = symbols_high_q;
			default:          prdata = '0;
		endcase
	end

	assign sym_tbl = {symbols_high_q, symbols_low_q};
	assign radix   = base_length_q;

	// Length must lie in 2..16; every in-use symbol must be legal and pairwise distinct.
	always_comb begin
		logic [SYM_W-1:0] si;
		ok_c = (base_length_q >= LEN_W'(2)) && (base_length_q <= LEN_W'(MAX_SYMBOLS));
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			si = table_byte(sym_tbl, DIGIT_W'(i));
			if (LEN_W'(i) < base_length_q) begin
				if (si == '0 || si == SYM_PLUS || si == SYM_MINUS) begin
					ok_c = 1'b0;
				end
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if (LEN_W'(j) < base_length_q && table_byte(sym_tbl, DIGIT_W'(j)) == si) begin
						ok_c = 1'b0;
					end
				end
			end
		end
	end

	assign base_ok = base_ok_q;

endmodule

// ===== hdl/srts_dp.sv =====
// Datapath: bit-serial divider, digit stack and output register.
module srts_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srts_pkg::cmd_t                      cmd,
	input  logic signed [srts_pkg::VALUE_WIDTH-1:0] value,
	input  logic [srts_pkg::LEN_W-1:0]          radix,
	input  logic [srts_pkg::TBL_W-1:0]          sym_tbl,
	output srts_pkg::stat_t                     stat,
	output logic [srts_pkg::SYM_W-1:0]          symbol,
	output logic                                last,
	output logic                                base_error
);
	import srts_pkg::*;

	logic [VALUE_WIDTH-1:0] work_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [BIT_W-1:0]       bit_q;
	logic [SYM_W-1:0]       symbol_q;
	logic                   last_q;
	logic                   err_q;

	logic [VALUE_WIDTH-1:0] value_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic [LEN_W-1:0]       trial;
	logic [LEN_W-1:0]       diff;
	logic                   ge;
	logic [DIGIT_W-1:0]     rd_digit;

	assign value_u = VALUE_WIDTH'(value);
	// Two's complement negate; the most negative value maps to its own magnitude.
	assign mag   = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
	assign trial = {rem_q, work_q[VALUE_WIDTH-1]};
	assign ge    = (trial >= radix);
	assign diff  = trial - radix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.load_in) begin
				cnt_q <= '0;
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= bit_q + 1'b1;
			end else if (cmd.digit_wr) begin
				cnt_q <= cnt_q + 1'b1;
				bit_q <= '0;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			work_q <= mag;
			neg_q  <= value_u[VALUE_WIDTH-1];
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			work_q <= {work_q[VALUE_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end else if (cmd.digit_wr) begin
			rem_q <= '0;
		end
		if (cmd.ld_err) begin
			symbol_q <= '0;
			last_q   <= 1'b1;
			err_q    <= 1'b1;
		end else if (cmd.ld_sign) begin
			symbol_q <= SYM_MINUS;
			last_q   <= 1'b0;
			err_q    <= 1'b0;
		end else if (cmd.ld_digit) begin
			symbol_q <= table_byte(sym_tbl, rd_digit);
			last_q   <= (cnt_q == CNT_W'(1));
			err_q    <= 1'b0;
		end
	end

	srts_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (cmd.digit_wr),
		.waddr (cnt_q[PTR_W-1:0]),
		.wdata (rem_q),
		.re    (cmd.rd_en),
		.raddr (PTR_W'(cnt_q - 1'b1)),
		.rdata (rd_digit)
	);

	assign stat.neg        = neg_q;
	assign stat.bit_last   = (bit_q == BIT_W'(VALUE_WIDTH - 1));
	assign stat.quot_zero  = (work_q == '0);
	assign stat.cnt_at_max = (cnt_q == CNT_W'(STACK_DEPTH - 1));
	assign stat.cnt_last   = (cnt_q == CNT_W'(1));

	assign symbol     = symbol_q;
	assign last       = last_q;
	assign base_error = err_q;

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> ({1'b0, rem_q} < radix))
		else $error("remainder not below radix during division");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("digit count beyond stack depth");

	a_digit_restarts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digit_wr |=> (bit_q == '0 && rem_q == '0))
		else $error("division not restarted after digit store");

endmodule

// ===== hdl/srts_ctrl.sv =====
// Controller state machine sequencing check, division and symbol emission.
module srts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  logic            base_ok,
	input  srts_pkg::stat_t stat,
	output srts_pkg::cmd_t  cmd
);
	import srts_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   conv_done;

	assign conv_done = stat.quot_zero || stat.cnt_at_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CHECK;
			ST_CHECK: state_d = base_ok ? ST_DIV : ST_ERR;
			ST_DIV:   if (stat.bit_last) state_d = ST_DIGIT;
			ST_DIGIT: begin
				if (!conv_done) begin
					state_d = ST_DIV;
				end else if (stat.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_SIGN:  if (!out_stall) state_d = ST_RD;
			ST_RD:    state_d = ST_LD;
			ST_LD:    state_d = ST_DOUT;
			ST_DOUT: begin
				if (!out_stall) begin
					state_d = stat.cnt_last ? ST_IDLE : ST_RD;
				end
			end
			ST_ERR:   if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_CHECK: cmd.ld_err = !base_ok;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_DIGIT: begin
				cmd.digit_wr = 1'b1;
				cmd.ld_sign  = conv_done && stat.neg;
			end
			ST_SIGN:  out_valid = 1'b1;
			ST_RD:    cmd.rd_en = 1'b1;
			ST_LD:    cmd.ld_digit = 1'b1;
			ST_DOUT: begin
				out_valid   = 1'b1;
				cmd.cnt_dec = !out_stall && !stat.cnt_last;
			end
			ST_ERR:   out_valid = 1'b1;
			default: ;
		endcase
	end

	a_ld_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD) |-> ($past(state_q) == ST_RD))
		else $error("digit load without preceding stack read");

	a_err_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERR && !out_stall) |=> (state_q == ST_IDLE))
		else $error("error transfer did not end the item");

	a_last_digit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOUT && !out_stall && stat.cnt_last) |=> (state_q == ST_IDLE))
		else $error("final symbol transfer did not end the item");

endmodule

// ===== hdl/signed_radix_to_symbols_top.sv =====
// Top level of the signed radix-to-symbols converter.
// Converts one signed 32-bit value per item into its text in the configured radix,
// most significant symbol first, one symbol per output transfer, with '-' ahead of
// negative values and last set on the final symbol. An invalid base (length outside
// 2..16, or a used symbol that is zero, '+', '-' or repeated) gives a single transfer
// with symbol 0, last 1 and base_error 1. One item is processed at a time: after
// acceptance and the base check, each digit comes from the bit-serial divider (one
// quotient bit per cycle, then the digit store), and each symbol is then read from
// the stack and output, waiting while the output is stalled (the sign symbol needs
// no stack read).
// Registers (64-bit APB data): base_length at 0x00, symbols_low at 0x08,
// symbols_high at 0x10; write only while no item is in flight.
module signed_radix_to_symbols_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [srts_pkg::ADDR_W-1:0]             paddr,
	input  logic [srts_pkg::CFG_W-1:0]              pwdata,
	output logic [srts_pkg::CFG_W-1:0]              prdata,
	output logic                                    pready,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [srts_pkg::VALUE_WIDTH-1:0] value,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [srts_pkg::SYM_W-1:0]              symbol,
	output logic                                    last,
	output logic                                    base_error
);
	import srts_pkg::*;

	logic [LEN_W-1:0] radix;
	logic [TBL_W-1:0] sym_tbl;
	logic             base_ok;
	cmd_t             cmd;
	stat_t            stat;

	srts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.radix   (radix),
		.sym_tbl (sym_tbl),
		.base_ok (base_ok)
	);

	srts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.base_ok   (base_ok),
		.stat      (stat),
		.cmd       (cmd)
	);

	srts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.radix      (radix),
		.sym_tbl    (sym_tbl),
		.stat       (stat),
		.symbol     (symbol),
		.last       (last),
		.base_error (base_error)
	);

endmodule

// ===== dv/srts_checker.sv =====
// Channel monitor, symbol-text predictor and scoreboard for the radix converter.
module srts_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [srts_pkg::ADDR_W-1:0]             paddr,
	input  logic [srts_pkg::CFG_W-1:0]              pwdata,
	input  logic                                    pready,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic signed [srts_pkg::VALUE_WIDTH-1:0] value,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic [srts_pkg::SYM_W-1:0]              symbol,
	input  logic                                    last,
	input  logic                                    base_error,
	output int                                      mismatches,
	output int                                      pending
);
	import srts_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             err;
	} symbol_rec_t;

	logic [LEN_W-1:0] cfg_len   = RST_BASE_LENGTH;
	logic [TBL_W-1:0] cfg_table = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};
	symbol_rec_t      text_q[$];

	function automatic logic base_is_valid(input logic [LEN_W-1:0] len,
			input logic [TBL_W-1:0] tbl);
		logic [SYM_W-1:0] s;
		if (len < 2 || len > MAX_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < len; i++) begin
			s = tbl[SYM_W*i +: SYM_W];
			if (s == '0 || s == SYM_PLUS || s == SYM_MINUS)
				return 1'b0;
			for (int j = i + 1; j < len; j++)
				if (tbl[SYM_W*j +: SYM_W] == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Expected text of one value under the current base, sign first, MSD first.
	function automatic void queue_text(input logic signed [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] mag;
		logic [VALUE_WIDTH-1:0] radix;
		logic [DIGIT_W-1:0]     digits [STACK_DEPTH];
		logic [DIGIT_W-1:0]     d;
		int                     n;
		symbol_rec_t            rec;
		if (!base_is_valid(cfg_len, cfg_table)) begin
			rec = '{sym: '0, last: 1'b1, err: 1'b1};
			text_q.push_back(rec);
			return;
		end
		radix = cfg_len;
		// most negative value wraps to its own unsigned magnitude
		mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
		n = 0;
		do begin
			digits[n] = DIGIT_W'(mag % radix);
			mag = mag / radix;
			n++;
		end while (mag != 0 && n < STACK_DEPTH);
		if (v[VALUE_WIDTH-1]) begin
			rec = '{sym: SYM_MINUS, last: 1'b0, err: 1'b0};
			text_q.push_back(rec);
		end
		for (int i = n - 1; i >= 0; i--) begin
			d = digits[i];
			rec = '{sym: cfg_table[SYM_W*d +: SYM_W], last: (i == 0), err: 1'b0};
			text_q.push_back(rec);
		end
	endfunction

	always @(posedge clk) begin : monitor
		symbol_rec_t got;
		symbol_rec_t want;
		if (!arst_n) begin
			cfg_len = RST_BASE_LENGTH;
			cfg_table = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};
			text_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_BASE_LENGTH:  cfg_len = pwdata[LEN_W-1:0];
					REG_SYMBOLS_LOW:  cfg_table[CFG_W-1:0] = pwdata;
					REG_SYMBOLS_HIGH: cfg_table[TBL_W-1:CFG_W] = pwdata;
					default: ;
				endcase
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = '{sym: symbol, last: last, err: base_error};
				if (text_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: symbol %02h last %b base_error %b",
							got.sym, got.last, got.err);
				end else begin
					want = text_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp symbol %02h last %b err %b, got %02h %b %b",
								want.sym, want.last, want.err, got.sym, got.last, got.err);
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				queue_text(value);
			pending = text_q.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the signed radix-to-symbols converter.
module testbench;
	import srts_pkg::*;

	// worst case ~480 items of up to 33 symbols each, with the longest stalls, taken several times
	localparam int LIMIT = 4_000_000;
	localparam int MAX_WAIT = 18;
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_ITEMS = 410;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [CFG_W-1:0] HEX_HIGH = 64'h4645444342413938;

	typedef enum int {BAD_LENGTH, BAD_ZERO, BAD_PLUS, BAD_MINUS, BAD_REPEAT} base_fault_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [ADDR_W-1:0]             paddr = '0;
	logic [CFG_W-1:0]              pwdata = '0;
	logic [CFG_W-1:0]              prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] value = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [SYM_W-1:0]              symbol;
	logic                          last;
	logic                          base_error;

	int mismatches;
	int pending;
	int cycles = 0;
	int stall_left = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;

	always #10 clk = ~clk;

	signed_radix_to_symbols_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.symbol(symbol), .last(last), .base_error(base_error)
	);

	srts_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.symbol(symbol), .last(last), .base_error(base_error),
		.mismatches(mismatches), .pending(pending)
	);

	// receiver: a fresh stall length after every accepted transfer
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_base(input logic [CFG_W-1:0] len_word, input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi);
		reg_write(REG_BASE_LENGTH, len_word);
		reg_write(REG_SYMBOLS_LOW, lo);
		reg_write(REG_SYMBOLS_HIGH, hi);
	endtask

	task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// block is idle once every symbol is out and the tail wait has passed
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] rand_value(input int radix);
		int pick;
		int k;
		longint p;
		logic [VALUE_WIDTH-1:0] rv;
		pick = $urandom_range(0, 9);
		if (radix < 2)
			radix = 2;
		if (pick < 3)
			return $urandom;
		if (pick < 5)
			return $urandom_range(0, 600) - 300;
		if (pick < 7) begin
			k = $urandom_range(0, 31);
			rv = $urandom >> k;
			return $urandom_range(0, 1) ? -rv : rv;
		end
		if (pick < 8) begin
			case ($urandom_range(0, 3))
				0: return 32'sh80000000;
				1: return 32'sh7FFFFFFF;
				2: return 0;
				default: return -1;
			endcase
		end
		// digit-count boundaries around powers of the radix
		p = 1;
		k = $urandom_range(0, 31);
		repeat (k)
			if (p * radix <= 64'sh80000000)
				p = p * radix;
		p = p + $urandom_range(0, 2) - 1;
		return VALUE_WIDTH'($urandom_range(0, 1) ? -p : p);
	endfunction

	task automatic pick_base(output logic [CFG_W-1:0] len_word, output logic [CFG_W-1:0] lo,
			output logic [CFG_W-1:0] hi, output int radix, output bit good);
		logic [TBL_W-1:0] tbl;
		logic [SYM_W-1:0] s;
		bit used [256];
		int len;
		int pos;
		int j;
		base_fault_t fault;
		foreach (used[n])
			used[n] = 1'b0;
		good = ($urandom_range(0, 4) != 0);
		len = $urandom_range(2, MAX_SYMBOLS);
		tbl = {$urandom, $urandom, $urandom, $urandom};
		for (int i = 0; i < len; i++) begin
			do s = SYM_W'($urandom_range(1, 255));
			while (s == SYM_PLUS || s == SYM_MINUS || used[s]);
			used[s] = 1'b1;
			tbl[SYM_W*i +: SYM_W] = s;
		end
		if (!good) begin
			fault = base_fault_t'($urandom_range(0, 4));
			pos = $urandom_range(0, len - 1);
			case (fault)
				BAD_LENGTH: len = $urandom_range(0, 1) ? $urandom_range(0, 1)
					: $urandom_range(17, 31);
				BAD_ZERO:   tbl[SYM_W*pos +: SYM_W] = '0;
				BAD_PLUS:   tbl[SYM_W*pos +: SYM_W] = SYM_PLUS;
				BAD_MINUS:  tbl[SYM_W*pos +: SYM_W] = SYM_MINUS;
				default: begin
					j = $urandom_range(0, len - 1);
					if (j == pos)
						j = (pos + 1) % len;
					tbl[SYM_W*pos +: SYM_W] = tbl[SYM_W*j +: SYM_W];
				end
			endcase
		end
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = LEN_W'(len);
		lo = tbl[CFG_W-1:0];
		hi = tbl[TBL_W-1:CFG_W];
		radix = len;
	endtask

	initial begin
		logic [CFG_W-1:0] len_word;
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		int radix;
		int n;
		bit good;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// decimal table out of reset
		send_value(0);
		send_value(1);
		send_value(-1);
		send_value(32'sh7FFFFFFF);
		send_value(32'sh80000000);
		drain();
		reg_write(REG_UNUSED, {$urandom, $urandom});
		send_value(9);
		send_value(10);
		send_value(-987654321);
		drain();

		// hex, full 16-symbol table
		set_base(64'd16, RST_SYMBOLS_LOW, HEX_HIGH);
		send_value(32'shDEADBEEF);
		send_value(32'sh7FFFFFFF);
		send_value(255);
		drain();

		// binary: longest texts
		set_base(64'd2, 64'hFFFF_FFFF_FFFF_4C48, '0);
		send_value(32'sh80000000);
		send_value(-1);
		send_value(32'sh7FFFFFFF);
		drain();

		// bytes past the length hold zero, sign symbols and repeats
		set_base(64'd3, 64'h612D2D2B00636261, '1);
		send_value(-5);
		send_value(0);
		drain();

		// invalid bases
		set_base(64'd0, RST_SYMBOLS_LOW, RST_SYMBOLS_HIGH);
		send_value(rand_value(10));
		drain();
		set_base(64'd1, RST_SYMBOLS_LOW, RST_SYMBOLS_HIGH);
		send_value(rand_value(10));
		drain();
		set_base(64'd17, RST_SYMBOLS_LOW, HEX_HIGH);
		send_value(rand_value(10));
		drain();
		set_base('1, RST_SYMBOLS_LOW, HEX_HIGH);
		send_value(rand_value(10));
		drain();
		set_base(64'd10, RST_SYMBOLS_LOW & ~(64'hFF << 24), RST_SYMBOLS_HIGH);
		send_value(rand_value(10));
		drain();
		set_base(64'd16, RST_SYMBOLS_LOW, {SYM_PLUS, HEX_HIGH[55:0]});
		send_value(rand_value(10));
		drain();
		set_base(64'd10, {RST_SYMBOLS_LOW[63:8], SYM_MINUS}, RST_SYMBOLS_HIGH);
		send_value(rand_value(10));
		drain();
		set_base(64'd10, RST_SYMBOLS_LOW, 64'h0000000000003338);
		send_value(rand_value(10));
		drain();
		set_base(64'd16, '1, '1);
		send_value(rand_value(10));
		drain();

		// random phases, each under its own base
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			pick_base(len_word, lo, hi, radix, good);
			set_base(len_word, lo, hi);
			no_idle = ($urandom_range(0, 4) == 0);
			n = good ? $urandom_range(15, 40) : $urandom_range(1, 4);
			repeat (n)
				send_value(rand_value(good ? radix : 10));
			drain();
			no_idle = 1'b0;
		end

		drain();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== signed_radix_to_symbols_top.f =====
hdl/srts_pkg.sv
hdl/srts_ram.sv
hdl/srts_cfg.sv
hdl/srts_dp.sv
hdl/srts_ctrl.sv
hdl/signed_radix_to_symbols_top.sv
dv/srts_checker.sv
dv/testbench.sv
